>>> rtl/core/gamepad_serial_link_master_defines.svh
// ----------------------------------------------------------------------------
// Gamepad serial link master - assertion macros
// Shared concurrent assertion forms for the link master RTL.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_SERIAL_LINK_MASTER_DEFINES_SVH
`define GAMEPAD_SERIAL_LINK_MASTER_DEFINES_SVH

// same-cycle implication
`define GSLM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GSLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/gslm_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad serial link master - package
// Phase codes, frame tables, register map and result type.
// ----------------------------------------------------------------------------
package gslm_pkg;

   localparam int FRAME_BYTES = 9;
   localparam int TABLE_BYTES = 9;
   localparam int NUM_KINDS   = 6;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_HALF_BIT = 1'b0;
   localparam logic REG_GAP      = 1'b1;

   localparam logic [7:0] HALF_BIT_RESET = 8'd8;
   localparam logic [7:0] GAP_RESET      = 8'd24;

   typedef logic [7:0] byte_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_HIGH,
      PH_LOW,
      PH_GAP,
      PH_TAIL
   } phase_type;

   localparam logic [2:0] KIND_POLL  = 3'd0;
   localparam logic [2:0] KIND_SHORT = 3'd1;
   localparam logic [2:0] KIND_ENTER = 3'd2;
   localparam logic [2:0] KIND_LOCK  = 3'd3;
   localparam logic [2:0] KIND_VIB   = 3'd4;
   localparam logic [2:0] KIND_EXIT  = 3'd5;

   localparam logic [3:0] POS_MOTOR_R = 4'd3;
   localparam logic [3:0] POS_MOTOR_L = 4'd4;

   localparam logic [3:0] SHORT_LEN = 4'd5;
   localparam logic [3:0] LONG_LEN  = 4'd9;

   localparam byte_type KIND_BYTES [NUM_KINDS][TABLE_BYTES] = '{
      '{8'h01, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h43, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h44, 8'h00, 8'h01, 8'hEE, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h4D, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A}
   };

   typedef struct packed {
      logic       clk_out;
      logic       cmd_out;
      logic       att_out;
      logic       busy_res;
      logic       byte_valid;
      logic [3:0] byte_index;
      byte_type   byte_value;
      logic       frame_done;
   } result_type;

   function automatic logic [3:0] frame_len(input logic [2:0] kind);
      logic [3:0] n;
      n = (kind == KIND_SHORT || kind == KIND_VIB) ? SHORT_LEN : LONG_LEN;
      if (n > 4'(FRAME_BYTES)) begin
         n = 4'(FRAME_BYTES);
      end
      return n;
   endfunction

   function automatic byte_type tx_byte(input logic [2:0] kind, input logic [3:0] idx,
                                        input byte_type mr, input byte_type ml);
      logic [2:0] k;
      logic [3:0] i;
      k = (kind < 3'(NUM_KINDS)) ? kind : KIND_SHORT;
      i = (idx < 4'(TABLE_BYTES)) ? idx : 4'(TABLE_BYTES - 1);
      if (k == KIND_POLL && i == POS_MOTOR_R) begin
         return mr;
      end
      if (k == KIND_POLL && i == POS_MOTOR_L) begin
         return ml;
      end
      return KIND_BYTES[k][i];
   endfunction

endpackage

>>> rtl/core/gslm_req_if.sv
// ----------------------------------------------------------------------------
// Gamepad serial link master - tick channel
// Valid/ready channel carrying one timebase tick with its pin sample.
// ----------------------------------------------------------------------------
interface gslm_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic [2:0] cmd;
   logic [7:0] motor_right;
   logic [7:0] motor_left;
   logic       dat_in;

   modport source (output valid, start_req, cmd, motor_right, motor_left, dat_in,
                   input ready);
   modport sink   (input valid, start_req, cmd, motor_right, motor_left, dat_in,
                   output ready);
endinterface

>>> rtl/core/gslm_rsp_if.sv
// ----------------------------------------------------------------------------
// Gamepad serial link master - pin level channel
// Valid/ready channel carrying the pin levels and receive report of one tick.
// ----------------------------------------------------------------------------
interface gslm_rsp_if;
   logic       valid;
   logic       ready;
   logic       clk_out;
   logic       cmd_out;
   logic       att_out;
   logic       busy_res;
   logic       byte_valid;
   logic [3:0] byte_index;
   logic [7:0] byte_value;
   logic       frame_done;

   modport source (output valid, clk_out, cmd_out, att_out, busy_res, byte_valid,
                   byte_index, byte_value, frame_done, input ready);
   modport sink   (input valid, clk_out, cmd_out, att_out, busy_res, byte_valid,
                   byte_index, byte_value, frame_done, output ready);
endinterface

>>> rtl/core/gamepad_serial_link_master.sv
// ----------------------------------------------------------------------------
// Gamepad serial link master
// Controller-host frame engine driven by a microsecond tick stream.
// ----------------------------------------------------------------------------
// Each item on req_ch is one timebase tick: a start request with frame kind
// and motor bytes, plus the sampled data-line level. Each tick gives exactly
// one item on rsp_ch: clock, command and attention pin levels, busy flag,
// a received-byte report (index and value) and a frame-done flag.
// The result of a tick sits in the output register the cycle after the tick
// is taken. One tick is accepted per cycle while rsp_ch does not stall; the
// frame state and the output register update together from the same tick.
// When rsp_ch stalls, the output register holds its item and req_ch.ready
// drops until it is taken; it stays high while the register drains.
// Reset (synchronous, active high) returns to idle, empties the output
// register and sets half_bit_ticks to 8 and gap_ticks to 24.
// The APB port (csr_*) holds half_bit_ticks at 0x0 and gap_ticks at 0x4;
// write them only while no frame runs. Power-up frame order is up to the host.
// ----------------------------------------------------------------------------
`include "gamepad_serial_link_master_defines.svh"

module gamepad_serial_link_master (
   input  logic                                  clock,
   input  logic                                  reset,
   gslm_req_if.sink                              req_ch,
   gslm_rsp_if.source                            rsp_ch,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [gslm_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [gslm_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [gslm_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   gslm_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]           tick_ff, tick_in;
   logic [2:0]           bit_ff, bit_in;
   logic [3:0]           byte_ff, byte_in;
   gslm_pkg::byte_type   rx_ff, rx_in;
   logic [2:0]           kind_ff, kind_in;
   gslm_pkg::byte_type   mr_ff, mr_in;
   gslm_pkg::byte_type   ml_ff, ml_in;
   logic [7:0]           half_ff;
   logic [7:0]           gap_ff;

   gslm_pkg::result_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff;

   gslm_pkg::phase_type  ph_cur;
   logic [7:0]           tick_cur;
   logic [2:0]           bit_cur;
   logic [3:0]           byte_cur;
   gslm_pkg::byte_type   rx_cur;
   logic [2:0]           kind_cur;
   gslm_pkg::byte_type   mr_cur;
   gslm_pkg::byte_type   ml_cur;

   logic                 start_ok;
   logic                 req_fire;
   logic                 csr_wr;
   logic [7:0]           hb;
   logic [7:0]           tail_lim;
   logic [8:0]           tick_inc;
   logic                 gap_end;
   logic                 hb_end;
   logic                 tail_end;
   gslm_pkg::byte_type   rx_new;
   logic [3:0]           byte_nxt;
   gslm_pkg::byte_type   tx_cur;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // a start while idle with a known frame kind loads the frame and is itself the first tick
   assign start_ok = (phase_ff == gslm_pkg::PH_IDLE) && req_ch.start_req &&
                     (req_ch.cmd < 3'(gslm_pkg::NUM_KINDS));

   always_comb begin
      ph_cur   = phase_ff;
      tick_cur = tick_ff;
      bit_cur  = bit_ff;
      byte_cur = byte_ff;
      rx_cur   = rx_ff;
      kind_cur = kind_ff;
      mr_cur   = mr_ff;
      ml_cur   = ml_ff;
      if (start_ok) begin
         ph_cur   = (gap_ff != 8'd0) ? gslm_pkg::PH_LEAD : gslm_pkg::PH_HIGH;
         tick_cur = 8'd0;
         bit_cur  = 3'd0;
         byte_cur = 4'd0;
         rx_cur   = 8'd0;
         kind_cur = req_ch.cmd;
         mr_cur   = req_ch.motor_right;
         ml_cur   = req_ch.motor_left;
      end
   end

   assign hb       = (half_ff == 8'd0) ? 8'd1 : half_ff;
   assign tail_lim = (gap_ff == 8'd0) ? 8'd1 : gap_ff;
   assign tick_inc = {1'b0, tick_cur} + 9'd1;
   assign gap_end  = tick_inc >= {1'b0, gap_ff};
   assign hb_end   = tick_inc >= {1'b0, hb};
   assign tail_end = tick_inc >= {1'b0, tail_lim};
   assign rx_new   = {req_ch.dat_in, rx_cur[7:1]};
   assign byte_nxt = byte_cur + 4'd1;
   assign tx_cur   = gslm_pkg::tx_byte(kind_cur, byte_cur, mr_cur, ml_cur);

   // next state
   always_comb begin
      phase_in = ph_cur;
      tick_in  = tick_inc[7:0];
      bit_in   = bit_cur;
      byte_in  = byte_cur;
      rx_in    = rx_cur;
      kind_in  = kind_cur;
      mr_in    = mr_cur;
      ml_in    = ml_cur;
      case (ph_cur)
         gslm_pkg::PH_LEAD: begin
            if (gap_end) begin
               tick_in  = 8'd0;
               phase_in = gslm_pkg::PH_HIGH;
            end
         end
         gslm_pkg::PH_HIGH: begin
            if (hb_end) begin
               tick_in  = 8'd0;
               phase_in = gslm_pkg::PH_LOW;
            end
         end
         gslm_pkg::PH_LOW: begin
            if (hb_end) begin
               tick_in = 8'd0;
               rx_in   = rx_new;
               if (bit_cur == 3'd7) begin
                  bit_in  = 3'd0;
                  byte_in = byte_nxt;
                  if (gap_ff != 8'd0) begin
                     phase_in = gslm_pkg::PH_GAP;
                  end else if (byte_nxt < gslm_pkg::frame_len(kind_cur)) begin
                     phase_in = gslm_pkg::PH_HIGH;
                  end else begin
                     phase_in = gslm_pkg::PH_TAIL;
                  end
               end else begin
                  bit_in   = bit_cur + 3'd1;
                  phase_in = gslm_pkg::PH_HIGH;
               end
            end
         end
         gslm_pkg::PH_GAP: begin
            if (gap_end) begin
               tick_in  = 8'd0;
               phase_in = (byte_cur < gslm_pkg::frame_len(kind_cur)) ?
                          gslm_pkg::PH_HIGH : gslm_pkg::PH_TAIL;
            end
         end
         gslm_pkg::PH_TAIL: begin
            if (tail_end) begin
               phase_in = gslm_pkg::PH_IDLE;
               tick_in  = 8'd0;
               bit_in   = 3'd0;
               byte_in  = 4'd0;
            end
         end
         default: begin
            phase_in = gslm_pkg::PH_IDLE;
            tick_in  = tick_cur;
         end
      endcase
   end

   // pin levels and receive report of this tick
   always_comb begin
      rsp_in            = '0;
      rsp_in.clk_out    = 1'b1;
      rsp_in.cmd_out    = 1'b1;
      rsp_in.att_out    = 1'b1;
      case (ph_cur)
         gslm_pkg::PH_LEAD, gslm_pkg::PH_GAP: begin
            rsp_in.att_out  = 1'b0;
            rsp_in.busy_res = 1'b1;
         end
         gslm_pkg::PH_HIGH: begin
            rsp_in.att_out  = 1'b0;
            rsp_in.busy_res = 1'b1;
            rsp_in.cmd_out  = tx_cur[bit_cur];
         end
         gslm_pkg::PH_LOW: begin
            rsp_in.att_out  = 1'b0;
            rsp_in.busy_res = 1'b1;
            rsp_in.clk_out  = 1'b0;
            rsp_in.cmd_out  = tx_cur[bit_cur];
            if (hb_end && bit_cur == 3'd7) begin
               rsp_in.byte_valid = 1'b1;
               rsp_in.byte_index = byte_cur;
               rsp_in.byte_value = rx_new;
            end
         end
         gslm_pkg::PH_TAIL: begin
            rsp_in.busy_res   = 1'b1;
            rsp_in.frame_done = tail_end;
         end
         default: begin
            rsp_in.busy_res = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= gslm_pkg::PH_IDLE;
         tick_ff  <= 8'd0;
         bit_ff   <= 3'd0;
         byte_ff  <= 4'd0;
         rx_ff    <= 8'd0;
         kind_ff  <= gslm_pkg::KIND_POLL;
         mr_ff    <= 8'd0;
         ml_ff    <= 8'd0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         rx_ff    <= rx_in;
         kind_ff  <= kind_in;
         mr_ff    <= mr_in;
         ml_ff    <= ml_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.clk_out    = rsp_ff.clk_out;
   assign rsp_ch.cmd_out    = rsp_ff.cmd_out;
   assign rsp_ch.att_out    = rsp_ff.att_out;
   assign rsp_ch.busy_res   = rsp_ff.busy_res;
   assign rsp_ch.byte_valid = rsp_ff.byte_valid;
   assign rsp_ch.byte_index = rsp_ff.byte_index;
   assign rsp_ch.byte_value = rsp_ff.byte_value;
   assign rsp_ch.frame_done = rsp_ff.frame_done;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= gslm_pkg::HALF_BIT_RESET;
         gap_ff  <= gslm_pkg::GAP_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            gslm_pkg::REG_HALF_BIT: half_ff <= csr_pwdata[7:0];
            gslm_pkg::REG_GAP:      gap_ff  <= csr_pwdata[7:0];
            default:                half_ff <= half_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         gslm_pkg::REG_HALF_BIT: csr_prdata = {24'd0, half_ff};
         gslm_pkg::REG_GAP:      csr_prdata = {24'd0, gap_ff};
         default:                csr_prdata = '0;
      endcase
   end

   `GSLM_ASSERT_NOW(a_stall_only_when_full, clock, reset, !req_ch.ready, rsp_valid_ff, "ready low with empty output register")
   `GSLM_ASSERT_NEXT(a_done_returns_idle, clock, reset, req_fire && rsp_in.frame_done, phase_ff == gslm_pkg::PH_IDLE, "frame done did not return to idle")
   `GSLM_ASSERT_NEXT(a_kind_held_in_frame, clock, reset, phase_ff != gslm_pkg::PH_IDLE, $stable(kind_ff) && $stable(mr_ff) && $stable(ml_ff), "frame kind or motor bytes changed mid-frame")
   `GSLM_ASSERT_NOW(a_bit_count_in_bit, clock, reset, bit_ff != 3'd0, phase_ff == gslm_pkg::PH_HIGH || phase_ff == gslm_pkg::PH_LOW, "bit count set outside a bit")

endmodule
